[rtl/adsc_pkg.sv]
// Shared types and constants of the area-average downscaler.
package adsc_pkg;

	localparam int DIM_W    = 11;
	localparam int PIX_W    = 8;
	localparam int SUM_W    = 30;
	localparam int N_W      = 2 * DIM_W;
	localparam int DIVD_W   = 2 * DIM_W;
	localparam int REG_IDX_W = 2;
	localparam int QUOT_STEPS = PIX_W;

	localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_WIDTH  = 2'd2;

	localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 11'd640;
	localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 11'd480;
	localparam logic [DIM_W-1:0] RST_MAX_WIDTH  = 11'd0;

	typedef struct packed {
		logic [DIM_W-1:0] src_width;
		logic [DIM_W-1:0] src_height;
		logic [DIM_W-1:0] max_width;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
		logic [N_W-1:0]   count;
		logic             row_last;
		logic             frame_last;
	} blk_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIM_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIM_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_F_OH,
		ST_F_CE,
		ST_F_BE,
		ST_READ,
		ST_ACC,
		ST_COL,
		ST_BAND
	} front_state_t;

endpackage

[rtl/adsc_sdiv.sv]
// Iterative restoring divider for output height and boundaries, one quotient bit per cycle.
module adsc_sdiv
	import adsc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp,
	output logic     busy
);

	localparam int CNT_W = $clog2(DIVD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W-1:0]  div_q;
	logic [DIVD_W-1:0] sh_q;
	logic [DIM_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, sh_q[DIVD_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			div_q <= req.divisor;
			sh_q  <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? DIM_W'(trial - {1'b0, div_q}) : trial[DIM_W-1:0];
			sh_q  <= {sh_q[DIVD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q[DIM_W-1:0];
	assign busy     = busy_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) req.start |-> !busy_q)
		else $error("Divider started while busy.");

endmodule

[rtl/adsc_front.sv]
// Front part: takes source pixels, tracks block boundaries and accumulates column sums.
module adsc_front
	import adsc_pkg::*;
#(
	parameter int MAX_SRC_WIDTH  = 1024,
	parameter int MAX_SRC_HEIGHT = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             push,
	output logic             full,
	input  logic [PIX_W-1:0] in_red,
	input  logic [PIX_W-1:0] in_green,
	input  logic [PIX_W-1:0] in_blue,
	output logic             q_push,
	output blk_t             q_entry,
	input  logic             q_full,
	output div_req_t         div_req,
	input  div_rsp_t         div_rsp
);

	localparam int AW = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;

	front_state_t state_q, state_d;

	logic [3*SUM_W-1:0] mem [MAX_SRC_WIDTH];
	logic [3*SUM_W-1:0] rd_q;
	logic [3*SUM_W-1:0] wr_data;

	logic [PIX_W-1:0] red_q, green_q, blue_q;
	logic [DIM_W-1:0] sc_q, sr_q, oc_q, or_q;
	logic [DIM_W-1:0] cs_q, ce_q, bs_q, be_q, ce1_q;
	logic [DIM_W-1:0] ow_q, oh_q, esw_q, esh_q;
	logic             div_wait_q;

	logic [DIM_W-1:0] esw_c, esh_c;
	logic             down_c;
	logic             first_px, first_blk, blk_done, advance;
	logic [DIM_W:0]   sc_inc, sr_inc;
	logic [DIM_W-1:0] mul_a, mul_b, div_d;
	logic             div_state;
	logic [SUM_W-1:0] sum_r, sum_g, sum_b;
	logic             rl;

	assign esw_c = (cfg.src_width == '0) ? DIM_W'(1) :
		(32'(cfg.src_width) > MAX_SRC_WIDTH) ? DIM_W'(MAX_SRC_WIDTH) : cfg.src_width;
	assign esh_c = (cfg.src_height == '0) ? DIM_W'(1) :
		(32'(cfg.src_height) > MAX_SRC_HEIGHT) ? DIM_W'(MAX_SRC_HEIGHT) : cfg.src_height;
	assign down_c = (cfg.max_width != '0) && (esw_c > cfg.max_width);

	assign first_px  = (sc_q == '0) && (sr_q == '0);
	assign first_blk = (sr_q == bs_q) && (sc_q == cs_q);
	assign sc_inc    = {1'b0, sc_q} + 1'b1;
	assign sr_inc    = {1'b0, sr_q} + 1'b1;
	assign blk_done  = (sr_inc == {1'b0, be_q}) && (sc_inc == {1'b0, ce_q});
	assign advance   = (state_q == ST_ACC) && !(blk_done && q_full);

	always_comb begin
		if (first_blk) begin
			sum_r = SUM_W'(red_q);
			sum_g = SUM_W'(green_q);
			sum_b = SUM_W'(blue_q);
		end else begin
			sum_r = rd_q[3*SUM_W-1:2*SUM_W] + SUM_W'(red_q);
			sum_g = rd_q[2*SUM_W-1:SUM_W] + SUM_W'(green_q);
			sum_b = rd_q[SUM_W-1:0] + SUM_W'(blue_q);
		end
	end
	assign wr_data = {sum_r, sum_g, sum_b};

	assign rl                 = (DIM_W'(oc_q + 1'b1) == ow_q);
	assign q_push             = advance && blk_done;
	assign q_entry.sum_red    = sum_r;
	assign q_entry.sum_green  = sum_g;
	assign q_entry.sum_blue   = sum_b;
	assign q_entry.count      = {{DIM_W{1'b0}}, DIM_W'(ce_q - cs_q)} *
		{{DIM_W{1'b0}}, DIM_W'(be_q - bs_q)};
	assign q_entry.row_last   = rl;
	assign q_entry.frame_last = rl && (DIM_W'(or_q + 1'b1) == oh_q);

	always_comb begin
		mul_a     = DIM_W'(1);
		mul_b     = esw_q;
		div_d     = ow_q;
		div_state = 1'b1;
		case (state_q)
			ST_F_OH: begin
				mul_a = esh_q;
				mul_b = ow_q;
				div_d = esw_q;
			end
			ST_F_CE: begin
				mul_b = esw_q;
				div_d = ow_q;
			end
			ST_F_BE: begin
				mul_b = esh_q;
				div_d = oh_q;
			end
			ST_COL: begin
				mul_a = DIM_W'(oc_q + 1'b1);
				mul_b = esw_q;
				div_d = ow_q;
			end
			ST_BAND: begin
				mul_a = DIM_W'(or_q + 1'b1);
				mul_b = esh_q;
				div_d = oh_q;
			end
			default: div_state = 1'b0;
		endcase
	end

	assign div_req.start    = div_state && !div_wait_q;
	assign div_req.dividend = {{DIM_W{1'b0}}, mul_a} * {{DIM_W{1'b0}}, mul_b};
	assign div_req.divisor  = div_d;

	always_comb begin
		state_d = state_q;
		full    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (push) begin
					if (first_px) begin
						state_d = down_c ? ST_F_OH : ST_F_CE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_F_OH: if (div_rsp.done) state_d = ST_F_CE;
			ST_F_CE: if (div_rsp.done) state_d = ST_F_BE;
			ST_F_BE: if (div_rsp.done) state_d = ST_READ;
			ST_READ: state_d = ST_ACC;
			ST_ACC: begin
				if (advance) begin
					if (sc_inc >= {1'b0, esw_q}) begin
						if (sr_inc >= {1'b0, esh_q}) begin
							state_d = ST_IDLE;
						end else if (sr_inc >= {1'b0, be_q}) begin
							state_d = ST_BAND;
						end else begin
							state_d = ST_IDLE;
						end
					end else if (sc_inc >= {1'b0, ce_q}) begin
						state_d = ST_COL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_COL:  if (div_rsp.done) state_d = ST_IDLE;
			ST_BAND: if (div_rsp.done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_wait_q <= 1'b0;
			sc_q       <= '0;
			sr_q       <= '0;
			oc_q       <= '0;
			or_q       <= '0;
			cs_q       <= '0;
			bs_q       <= '0;
		end else begin
			if (div_req.start) begin
				div_wait_q <= 1'b1;
			end else if (div_rsp.done) begin
				div_wait_q <= 1'b0;
			end
			if (state_q == ST_IDLE && push && first_px) begin
				oc_q <= '0;
				or_q <= '0;
				cs_q <= '0;
				bs_q <= '0;
			end
			if (advance) begin
				if (sc_inc >= {1'b0, esw_q}) begin
					sc_q <= '0;
					oc_q <= '0;
					cs_q <= '0;
					if (sr_inc >= {1'b0, esh_q}) begin
						sr_q <= '0;
						or_q <= '0;
						bs_q <= '0;
					end else begin
						sr_q <= sr_inc[DIM_W-1:0];
						if (sr_inc >= {1'b0, be_q}) begin
							or_q <= DIM_W'(or_q + 1'b1);
							bs_q <= be_q;
						end
					end
				end else begin
					sc_q <= sc_inc[DIM_W-1:0];
					if (sc_inc >= {1'b0, ce_q}) begin
						oc_q <= DIM_W'(oc_q + 1'b1);
						cs_q <= ce_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && push) begin
			red_q   <= in_red;
			green_q <= in_green;
			blue_q  <= in_blue;
			if (first_px) begin
				esw_q <= esw_c;
				esh_q <= esh_c;
				ow_q  <= down_c ? cfg.max_width : esw_c;
				oh_q  <= esh_c;
			end
		end
		if (div_rsp.done) begin
			case (state_q)
				ST_F_OH: oh_q <= (div_rsp.quot == '0) ? DIM_W'(1) : div_rsp.quot;
				ST_F_CE: begin
					ce_q  <= div_rsp.quot;
					ce1_q <= div_rsp.quot;
				end
				ST_F_BE: be_q <= div_rsp.quot;
				ST_COL:  ce_q <= div_rsp.quot;
				ST_BAND: be_q <= div_rsp.quot;
				default: ;
			endcase
		end
		if (advance && sc_inc >= {1'b0, esw_q}) begin
			ce_q <= ce1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= mem[AW'(oc_q)];
		end
		if (advance) begin
			mem[AW'(oc_q)] <= wr_data;
		end
	end

endmodule

[rtl/adsc_queue.sv]
// Two-entry queue of finished blocks between the front and back parts.
module adsc_queue
	import adsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  blk_t wr_entry,
	output logic full,
	input  logic pop,
	output blk_t rd_entry,
	output logic empty
);

	blk_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Block queue written while full.");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("Block queue read while empty.");

endmodule

[rtl/adsc_back.sv]
// Back part: divides the block sums by the pixel count and holds the result word.
module adsc_back
	import adsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  blk_t             q_entry,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [PIX_W-1:0] avg_red,
	output logic [PIX_W-1:0] avg_green,
	output logic [PIX_W-1:0] avg_blue,
	output logic             row_last,
	output logic             frame_last
);

	localparam int STEP_W = $clog2(QUOT_STEPS + 1);

	logic              busy_q, out_valid_q;
	logic [STEP_W-1:0] cnt_q;
	logic [SUM_W-1:0]  rem_r_q, rem_g_q, rem_b_q, dsh_q;
	logic [PIX_W-1:0]  q_r_q, q_g_q, q_b_q;
	logic              rl_q, fl_q;
	logic [N_W-1:0]    n_c;
	logic              ge_r, ge_g, ge_b, fin, slot_free;

	assign n_c       = (q_entry.count == '0) ? N_W'(1) : q_entry.count;
	assign q_pop     = !busy_q && !q_empty;
	assign ge_r      = rem_r_q >= dsh_q;
	assign ge_g      = rem_g_q >= dsh_q;
	assign ge_b      = rem_b_q >= dsh_q;
	assign fin       = busy_q && (cnt_q == STEP_W'(QUOT_STEPS));
	assign slot_free = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (pop) out_valid_q <= 1'b0;
			if (q_pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (fin) begin
				if (slot_free) begin
					busy_q      <= 1'b0;
					out_valid_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_r_q <= q_entry.sum_red;
			rem_g_q <= q_entry.sum_green;
			rem_b_q <= q_entry.sum_blue;
			dsh_q   <= SUM_W'(n_c) << (QUOT_STEPS - 1);
			rl_q    <= q_entry.row_last;
			fl_q    <= q_entry.frame_last;
		end else if (busy_q && !fin) begin
			if (ge_r) rem_r_q <= rem_r_q - dsh_q;
			if (ge_g) rem_g_q <= rem_g_q - dsh_q;
			if (ge_b) rem_b_q <= rem_b_q - dsh_q;
			q_r_q <= {q_r_q[PIX_W-2:0], ge_r};
			q_g_q <= {q_g_q[PIX_W-2:0], ge_g};
			q_b_q <= {q_b_q[PIX_W-2:0], ge_b};
			dsh_q <= dsh_q >> 1;
		end
		if (fin && slot_free) begin
			avg_red    <= q_r_q;
			avg_green  <= q_g_q;
			avg_blue   <= q_b_q;
			row_last   <= rl_q;
			frame_last <= fl_q;
		end
	end

	assign empty = !out_valid_q;

endmodule

[rtl/area_average_downscale_core.sv]
// Top level of the area-average downscaler: configuration registers and its four parts.
// A source word is taken, its column sum read from the line store and the word accumulated.
// Crossing a column or band boundary adds one division; a frame's first word adds up to three.
// A result word appears once the back part has divided its block sums by the pixel count.
// The asynchronous reset clears the control state and loads 640, 480 and 0 into the registers.
// The line store is not cleared: each entry is written by the first word of its block.
module area_average_downscale_core
	import adsc_pkg::*;
#(
	parameter int MAX_SRC_WIDTH  = 1024,
	parameter int MAX_SRC_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic [PIX_W-1:0]     in_red,
	input  logic [PIX_W-1:0]     in_green,
	input  logic [PIX_W-1:0]     in_blue,
	output logic                 empty,
	input  logic                 pop,
	output logic [PIX_W-1:0]     avg_red,
	output logic [PIX_W-1:0]     avg_green,
	output logic [PIX_W-1:0]     avg_blue,
	output logic                 row_last,
	output logic                 frame_last
);

	cfg_t     cfg_q;
	logic     q_push, q_full, q_pop, q_empty, div_busy;
	blk_t     q_wr, q_rd;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width  <= RST_SRC_WIDTH;
			cfg_q.src_height <= RST_SRC_HEIGHT;
			cfg_q.max_width  <= RST_MAX_WIDTH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data;
				REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data;
				REG_MAX_WIDTH:  cfg_q.max_width  <= cfg_data;
				default: ;
			endcase
		end
	end

	adsc_front #(
		.MAX_SRC_WIDTH (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.in_red  (in_red),
		.in_green(in_green),
		.in_blue (in_blue),
		.q_push  (q_push),
		.q_entry (q_wr),
		.q_full  (q_full),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	adsc_sdiv u_sdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp),
		.busy  (div_busy)
	);

	adsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_entry(q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.rd_entry(q_rd),
		.empty   (q_empty)
	);

	adsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_entry   (q_rd),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.avg_red   (avg_red),
		.avg_green (avg_green),
		.avg_blue  (avg_blue),
		.row_last  (row_last),
		.frame_last(frame_last)
	);

	a_frame_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_last) |-> row_last)
		else $error("Frame end marked on a word that does not end a row.");
	a_no_div_while_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !q_push)
		else $error("Boundary division started while a block was being queued.");

endmodule
